FILE: src/isb_pkg.sv
package isb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = $clog2(LINE_DEPTH);
  localparam int POS_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 12;
  localparam int COORD_W    = 12;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 1;
  localparam int ADDR_W     = 3;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd640;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

  localparam logic MODE_UP   = 1'b0;
  localparam logic MODE_DOWN = 1'b1;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] left;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             mode;
  } item_t;

endpackage

FILE: src/isb_regs.sv
module isb_regs
  import isb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               mode,
  output logic [WIDTH_W-1:0] frame_width
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_UP;
      frame_width <= WIDTH_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MODE:  mode        <= pwdata[0];
        REG_WIDTH: frame_width <= pwdata[WIDTH_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_MODE:  prdata = {31'd0, mode};
      REG_WIDTH: prdata = {{(32-WIDTH_W){1'b0}}, frame_width};
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: src/isb_front.sv
module isb_front
  import isb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               mode,
  input  logic [WIDTH_W-1:0] frame_width,
  input  logic               s_tvalid,
  input  logic [PIX_W-1:0]   s_tdata,
  input  logic               s_tuser,
  input  logic               ready,
  output logic               load,
  output item_t              item,
  output logic [SUM_W-1:0]   line_sum
);

  logic [SUM_W-1:0]   line_mem [LINE_DEPTH];
  logic [POS_W-1:0]   column_count;
  logic [POS_W-1:0]   row_count;
  logic [PIX_W-1:0]   left_pixel;
  logic [POS_W-1:0]   column_count_next;
  logic [POS_W-1:0]   row_count_next;
  logic [WIDTH_W-1:0] width_eff;
  logic [POS_W-1:0]   r;
  logic [POS_W-1:0]   c;
  logic [WIDTH_W-1:0] c_plus;
  logic [SLOT_W-1:0]  slot;
  logic               accept;

  assign accept = s_tvalid && ready;

  always_comb begin
    if (frame_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (frame_width > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = frame_width;
    end
  end

  always_comb begin
    r = s_tuser ? '0 : row_count;
    c = s_tuser ? '0 : column_count;
    if ({1'b0, c} >= width_eff) begin
      c = '0;
    end
    c_plus = {1'b0, c} + WIDTH_W'(1);
    if (c_plus >= width_eff) begin
      column_count_next = '0;
      row_count_next    = r + POS_W'(1);
    end else begin
      column_count_next = c_plus[POS_W-1:0];
      row_count_next    = r;
    end
  end

  assign slot = c[POS_W-1:1];
  assign load = accept && ((mode == MODE_UP) || (r[0] && c[0]));

  always_comb begin
    item.pix  = s_tdata;
    item.left = left_pixel;
    item.row  = r;
    item.col  = c;
    item.mode = mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (!c[0]) begin
        left_pixel <= s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && c[0] && !r[0]) begin
      line_mem[slot] <= SUM_W'(left_pixel) + SUM_W'(s_tdata);
    end
    if (accept) begin
      line_sum <= line_mem[slot];
    end
  end

endmodule

FILE: src/isb_emit.sv
module isb_emit
  import isb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  item_t            item_in,
  input  logic [SUM_W-1:0] line_sum,
  output logic             ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,
  output logic             m_tlast
);

  item_t              item;
  logic               item_valid;
  logic [1:0]         idx;
  logic [SUM_W:0]     sum;
  logic [PIX_W-1:0]   res_pix;
  logic [COORD_W-1:0] res_row;
  logic [COORD_W-1:0] res_col;
  logic               res_last;
  logic               out_load;
  logic               advance;
  logic               item_done;

  assign sum = (SUM_W+1)'(line_sum) + (SUM_W+1)'(item.left) + (SUM_W+1)'(item.pix);

  always_comb begin
    if (item.mode == MODE_UP) begin
      res_pix  = item.pix;
      res_row  = {item.row, idx[1]};
      res_col  = {item.col, idx[0]};
      res_last = (idx == 2'd3);
    end else begin
      res_pix  = sum[SUM_W:2];
      res_row  = COORD_W'(item.row[POS_W-1:1]);
      res_col  = COORD_W'(item.col[POS_W-1:1]);
      res_last = 1'b1;
    end
  end

  assign out_load  = !m_tvalid || m_tready;
  assign advance   = item_valid && out_load;
  assign item_done = advance && res_last;
  assign ready     = !item_valid || item_done;

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      item_valid <= 1'b1;
      idx        <= '0;
    end else if (item_done) begin
      item_valid <= 1'b0;
      idx        <= '0;
    end else if (advance) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res_col, res_row, res_pix};
      m_tlast <= res_last;
    end
  end

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> idx == 2'd0)
    else $error("result index moved without an item");

  a_idx_down: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item.mode == MODE_DOWN) |-> idx == 2'd0)
    else $error("downscale item emitted more than one result");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_done) |=> item_valid)
    else $error("item dropped before its last result");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("item loaded while previous one still emitting");

endmodule

FILE: src/image_scale_by_two.sv
// Scales a raster stream of 8-bit grey pixels by two. Mode 0 repeats each
// source pixel as a 2x2 block (four results, tlast on the fourth), so the
// block takes a new pixel only as the previous one's last result is sent, set by the
// single output register that sends one result per cycle while m_tready is high.
// Mode 1 averages each 2x2 block (sum >> 2) using a 1024-entry line store of even-row
// pair sums and takes one pixel per cycle unless the output stalls; only odd-row,
// odd-column pixels produce a result, an odd last row or column gives none. tuser on
// the input marks the first pixel of a frame; frame_width sets the row wrap.
module image_scale_by_two
  import isb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] pixel
  input  logic              s_tuser,   // [0] frame_start
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [7:0] out_pixel, [19:8] out_row, [31:20] out_col
  output logic              m_tlast
);

  logic               mode;
  logic [WIDTH_W-1:0] frame_width;
  logic               ready;
  logic               load;
  item_t              item;
  logic [SUM_W-1:0]   line_sum;

  assign s_tready = ready;

  isb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mode        (mode),
    .frame_width (frame_width)
  );

  isb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .frame_width (frame_width),
    .s_tvalid    (s_tvalid),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .ready       (ready),
    .load        (load),
    .item        (item),
    .line_sum    (line_sum)
  );

  isb_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .item_in  (item),
    .line_sum (line_sum),
    .ready    (ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import isb_pkg::*;

  localparam int SETTLE_CYC  = 8;
  localparam int QUIET_LIMIT = 1000;
  localparam int RAND_ITEMS  = 200;

  localparam logic [ADDR_W-1:0] ADDR_MODE  = ADDR_W'(4 * REG_MODE);
  localparam logic [ADDR_W-1:0] ADDR_WIDTH = ADDR_W'(4 * REG_WIDTH);

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } out_px_t;

  typedef enum logic [1:0] {STEP_CFG, STEP_PIX, STEP_RUN} step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    logic [ADDR_W-1:0]  addr;
    logic [11:0]        value;
    logic [PIX_W-1:0]   pix;
    logic               fs;
    logic [11:0]        reps;
    logic               typed;
    logic [PIX_W-1:0]   t_pix;
    logic [COORD_W-1:0] t_row;
    logic [COORD_W-1:0] t_col;
  } step_t;

  // typed columns give the final result of the request
  localparam step_t PLAN [36] = '{
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'hFF, 1'b1, 12'd0,    1'b1, 8'hFF, 12'd1,    12'd1},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h00, 1'b0, 12'd0,    1'b1, 8'h00, 12'd1,    12'd3},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h5A, 1'b0, 12'd0,    1'b1, 8'h5A, 12'd1,    12'd5},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'hA5, 1'b1, 12'd0,    1'b1, 8'hA5, 12'd1,    12'd1},
    '{STEP_CFG, ADDR_WIDTH, 12'd0,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h01, 1'b1, 12'd0,    1'b1, 8'h01, 12'd1,    12'd1},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h80, 1'b0, 12'd0,    1'b1, 8'h80, 12'd3,    12'd1},
    '{STEP_CFG, ADDR_WIDTH, 12'd3,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_CFG, ADDR_MODE,  12'd1,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'hFF, 1'b1, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'hFF, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'hFF, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'hFF, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'hFF, 1'b0, 12'd0,    1'b1, 8'hFF, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'hFF, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h00, 1'b1, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h00, 1'b0, 12'd0,    1'b1, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h3C, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h77, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_CFG, ADDR_WIDTH, 12'd4,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_RUN, ADDR_MODE,  12'd0,    8'h00, 1'b1, 12'd12,   1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_CFG, ADDR_WIDTH, 12'd4095, 8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_RUN, ADDR_MODE,  12'd0,    8'h00, 1'b1, 12'd6,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_CFG, ADDR_MODE,  12'd0,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'hC3, 1'b0, 12'd0,    1'b1, 8'hC3, 12'd1,    12'd13},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h3C, 1'b0, 12'd0,    1'b1, 8'h3C, 12'd1,    12'd15},
    '{STEP_CFG, ADDR_MODE,  12'd1,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_RUN, ADDR_MODE,  12'd0,    8'h00, 1'b0, 12'd4,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_CFG, ADDR_WIDTH, 12'd1,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_RUN, ADDR_MODE,  12'd0,    8'h00, 1'b1, 12'd5,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_CFG, ADDR_MODE,  12'd0,    8'h00, 1'b0, 12'd0,    1'b0, 8'h00, 12'd0,    12'd0},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h96, 1'b0, 12'd0,    1'b1, 8'h96, 12'd11,   12'd1},
    '{STEP_PIX, ADDR_MODE,  12'd0,    8'h69, 1'b0, 12'd0,    1'b1, 8'h69, 12'd13,   12'd1}
  };

  logic              clk;
  logic              rst      = 1'b1;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;   // [7:0] pixel
  logic              s_tuser  = 1'b0; // [0] frame_start
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;         // [7:0] out_pixel, [19:8] out_row, [31:20] out_col
  logic              m_tlast;

  logic                   cur_mode;
  logic [WIDTH_W-1:0]     cur_width;
  logic [POS_W-1:0]       src_col;
  logic [POS_W-1:0]       src_row;
  logic [PIX_W-1:0]       left_px;
  logic [SUM_W-1:0]       pair_sums [LINE_DEPTH];
  out_px_t                due_px [$];
  int                     mismatch_cnt = 0;
  int                     quiet_cyc = 0;

  image_scale_by_two u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t MISMATCH %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic void add_due(input out_px_t px);
    due_px.insert(due_px.size(), px);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic void scale_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int w;
    int r;
    int c;
    int slot;
    int nxt;
    logic [SUM_W:0] sum;
    w = int'(cur_width);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (fs) begin
      src_col = '0;
      src_row = '0;
    end
    if (int'(src_col) >= w) src_col = '0;
    r = int'(src_row);
    c = int'(src_col);
    slot = (c / 2) % LINE_DEPTH;
    if (cur_mode == MODE_UP) begin
      add_due('{pix, COORD_W'(2 * r), COORD_W'(2 * c), 1'b0});
      add_due('{pix, COORD_W'(2 * r), COORD_W'(2 * c + 1), 1'b0});
      add_due('{pix, COORD_W'(2 * r + 1), COORD_W'(2 * c), 1'b0});
      add_due('{pix, COORD_W'(2 * r + 1), COORD_W'(2 * c + 1), 1'b1});
    end else if ((r % 2 == 1) && (c % 2 == 1)) begin
      sum = (SUM_W + 1)'(pair_sums[slot]) + (SUM_W + 1)'(left_px) + (SUM_W + 1)'(pix);
      add_due('{sum[SUM_W:2], COORD_W'(r / 2), COORD_W'(c / 2), 1'b1});
    end
    if (c % 2 == 0) begin
      left_px = pix;
    end else if (r % 2 == 0) begin
      pair_sums[slot] = SUM_W'(left_px) + SUM_W'(pix);
    end
    nxt = c + 1;
    if (nxt >= w) begin
      src_col = '0;
      nxt = r + 1;
      src_row = (nxt >= MAX_HEIGHT) ? '0 : POS_W'(nxt);
    end else begin
      src_col = POS_W'(nxt);
    end
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= fs;
    do @(posedge clk); while (!s_tready);
    scale_pixel(pix, fs);
  endtask

  // drain every pending result, then let in-flight requests clear
  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [11:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_MODE) begin
      cur_mode = value[0];
      want = 32'(value[0]);
    end else begin
      cur_width = value;
      want = 32'(value);
    end
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      flag_mismatch($sformatf("readback addr %0d: got %0h, expected %0h", addr, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    forever begin
      int stall;
      stall = pick_gap();
      @(posedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(0, 11)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_px_t got;
    out_px_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tdata[19:8], m_tdata[31:20], m_tlast};
      if (due_px.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: pixel %0d row %0d col %0d",
                                got.pix, got.row, got.col));
      end else begin
        want = due_px.pop_front();
        if (got.pix !== want.pix)
          flag_mismatch($sformatf("out_pixel got %0d, expected %0d", got.pix, want.pix));
        if (got.row !== want.row)
          flag_mismatch($sformatf("out_row got %0d, expected %0d", got.row, want.row));
        if (got.col !== want.col)
          flag_mismatch($sformatf("out_col got %0d, expected %0d", got.col, want.col));
        if (got.last !== want.last)
          flag_mismatch($sformatf("tlast got %0d, expected %0d", got.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cyc <= 0;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
    if (quiet_cyc >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int k;
    int rand_items;
    int npix;
    int weff;
    int pick;
    logic [11:0] new_width;
    logic new_mode;
    bit fast;

    cur_mode  = MODE_UP;
    cur_width = WIDTH_RESET;
    src_col   = '0;
    src_row   = '0;
    left_px   = '0;
    rand_items = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      case (PLAN[i].kind)
        STEP_CFG: begin
          settle();
          write_reg(PLAN[i].addr, PLAN[i].value);
        end
        STEP_PIX: begin
          push_pixel(PLAN[i].pix, PLAN[i].fs, pick_gap());
          if (PLAN[i].typed)
            due_px[due_px.size() - 1] = '{PLAN[i].t_pix, PLAN[i].t_row, PLAN[i].t_col, 1'b1};
        end
        default: begin
          for (k = 0; k < int'(PLAN[i].reps); k++)
            push_pixel(PIX_W'($urandom_range(0, 255)), PLAN[i].fs && (k == 0), pick_gap());
        end
      endcase
    end

    while (rand_items < RAND_ITEMS) begin
      new_mode = ($urandom_range(0, 1) == 1) ? MODE_DOWN : MODE_UP;
      pick = $urandom_range(0, 19);
      if (pick == 0) new_width = 12'd0;
      else if (pick == 1) new_width = 12'($urandom_range(MAX_WIDTH + 1, 4095));
      else if (pick < 6) new_width = 12'($urandom_range(9, 40));
      else new_width = 12'($urandom_range(1, 8));
      settle();
      if ($urandom_range(0, 1) == 1) begin
        write_reg(ADDR_MODE, 12'(new_mode));
        write_reg(ADDR_WIDTH, new_width);
      end else begin
        write_reg(ADDR_WIDTH, new_width);
        write_reg(ADDR_MODE, 12'(new_mode));
      end
      weff = (new_width == 0) ? 1 : int'(new_width);
      if (weff > MAX_WIDTH) begin
        npix = $urandom_range(1, 20);
      end else begin
        npix = weff * $urandom_range(1, 5) + $urandom_range(0, weff - 1);
        if (npix > 60) npix = 60;
      end
      fast = ($urandom_range(0, 3) == 0);
      // occasional frame restart mid-frame
      for (k = 0; k < npix; k++)
        push_pixel(PIX_W'($urandom_range(0, 255)), (k == 0) || ($urandom_range(0, 29) == 0),
                   fast ? 0 : pick_gap());
      rand_items += npix;
    end

    s_tvalid <= 1'b0;
    while (due_px.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/isb_pkg.sv
src/isb_regs.sv
src/isb_front.sv
src/isb_emit.sv
src/image_scale_by_two.sv
tb/tb_top.sv
